/* design/lmc_pkg.sv */
// Shared types and constants of the LRU miss counter.
// No dependencies; every other design file but lmc_cell refers to it by scoped names.
`default_nettype none

package lmc_pkg;

   localparam int REF_KEY_WIDTH    = 32;
   localparam int MISS_COUNT_WIDTH = 32;
   localparam int CAPACITY_WIDTH   = 5;

   localparam logic [CAPACITY_WIDTH-1:0]   CAPACITY_RESET = 5'd16;
   localparam logic [MISS_COUNT_WIDTH-1:0] MISS_COUNT_MAX = '1;

   typedef struct packed {
      logic signed [REF_KEY_WIDTH-1:0] ref_key;
   } req_word_type;

   typedef struct packed {
      logic                        hit;
      logic [MISS_COUNT_WIDTH-1:0] miss_count;
   } rsp_word_type;

   typedef struct packed {
      logic [CAPACITY_WIDTH-1:0] capacity;
   } csr_word_type;

endpackage

`default_nettype wire

/* design/lmc_stream_if.sv */
// Valid/ready channel carrying one word of a chosen payload type.
// Payload types come from lmc_pkg.
`default_nettype none

interface lmc_stream_if #(
   parameter type word_type = lmc_pkg::req_word_type
);
   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/lmc_cell.sv */
// One slot of the recency stack: stored key, match against the lookup key,
// and a shift from the neighbor nearer the most-recent end. Uses no package.
`default_nettype none

module lmc_cell #(
   parameter int KEY_WIDTH = 32,
   parameter int INDEX     = 0,
   parameter int IW        = 4,
   parameter int CW        = 5
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 hit,
   input  logic [IW-1:0]        miss_limit,
   input  logic [CW-1:0]        fill,
   input  logic [KEY_WIDTH-1:0] look_key,
   input  logic [KEY_WIDTH-1:0] key_in,
   input  logic                 match_in,
   output logic                 match_out,
   output logic [KEY_WIDTH-1:0] key_out
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_next_in;
   logic                 valid;
   logic                 shift;

   assign valid     = CW'(INDEX) < fill;
   // match_out: the hit slot sits here or farther from the front
   assign match_out = match_in | (valid && (key_ff == look_key));
   assign shift     = load && (hit ? match_out : (IW'(INDEX) <= miss_limit));
   assign key_next_in = shift ? key_in : key_ff;
   assign key_out   = key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_next_in;
   end

endmodule

`default_nettype wire

/* design/lmc_result_buffer.sv */
// Two-word output buffer (output register plus skid) for result words.
// Depends on lmc_pkg and lmc_stream_if.
`default_nettype none

module lmc_result_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lmc_pkg::rsp_word_type push_word,
   output logic                  push_ready,
   lmc_stream_if.source          rsp_if
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   lmc_pkg::rsp_word_type out_word_ff, out_word_in;
   lmc_pkg::rsp_word_type skid_word_ff, skid_word_in;
   logic                  pop;
   logic                  push;

   assign pop        = out_valid_ff && rsp_if.ready;
   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_word_ff;

endmodule

`default_nettype wire

/* design/lru_miss_counter.sv */
// Top level of the LRU miss counter: row of stack cells, fill and miss counters.
// Depends on lmc_pkg, lmc_stream_if, lmc_cell and lmc_result_buffer.
//
// Fully associative LRU cache model that counts misses. One reference word is
// taken per clock: the compare in every stack cell, the shift of the row and
// the counter updates all settle in the accept cycle, so the next word sees the
// updated stack at once. Each word gives one result word, registered into a
// two-word output buffer when it is taken; the input stalls only when both buffer
// words wait. Keys are compared on their low KEY_WIDTH bits after sign
// extension. capacity (reset 16) is clamped to 1..ENTRIES; lowering it below
// the fill level takes effect on the next miss. No clearing pass after reset.
`default_nettype none

module lru_miss_counter #(
   parameter int ENTRIES   = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   lmc_stream_if.sink   req_if,
   lmc_stream_if.source rsp_if,
   lmc_stream_if.sink   csr_if
);

   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMPW = (CW > lmc_pkg::CAPACITY_WIDTH) ? CW : lmc_pkg::CAPACITY_WIDTH;

   logic [lmc_pkg::CAPACITY_WIDTH-1:0]   capacity_ff, capacity_in;
   logic [CW-1:0]                        fill_ff, fill_in;
   logic [lmc_pkg::MISS_COUNT_WIDTH-1:0] misses_ff, misses_in;

   logic [63:0]            key_ext;
   logic [KEY_WIDTH-1:0]   look_key;
   logic [KEY_WIDTH-1:0]   cell_key [ENTRIES];
   logic [KEY_WIDTH-1:0]   key_feed [ENTRIES];
   logic [ENTRIES:0]       tail_match;
   logic                   load;
   logic                   hit;
   logic                   push_ready;
   logic [CMPW-1:0]        cap_ext;
   logic [CMPW-1:0]        eff_cap;
   logic [CMPW-1:0]        fill_ext;
   logic [CMPW-1:0]        keep;
   logic [CMPW-1:0]        keep_inc;
   logic [IW-1:0]          miss_limit;
   lmc_pkg::rsp_word_type  rsp_word;

   assign key_ext  = {{32{req_if.payload.ref_key[31]}}, req_if.payload.ref_key};
   assign look_key = key_ext[KEY_WIDTH-1:0];

   assign load         = req_if.valid && push_ready;
   assign req_if.ready = push_ready;
   assign csr_if.ready = 1'b1;

   // entries kept behind the new key on a miss
   assign cap_ext  = CMPW'(capacity_ff);
   assign eff_cap  = (cap_ext == '0) ? CMPW'(1) :
                     (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
   assign fill_ext = CMPW'(fill_ff);
   assign keep     = (fill_ext >= eff_cap) ? eff_cap - CMPW'(1) : fill_ext;
   assign keep_inc = keep + CMPW'(1);
   assign miss_limit = keep[IW-1:0];

   assign tail_match[ENTRIES] = 1'b0;
   assign hit                 = tail_match[0];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign key_feed[i] = look_key;
      end else begin : g_body
         assign key_feed[i] = cell_key[i-1];
      end
      lmc_cell #(
         .KEY_WIDTH (KEY_WIDTH),
         .INDEX     (i),
         .IW        (IW),
         .CW        (CW)
      ) u_cell (
         .clock      (clock),
         .load       (load),
         .hit        (hit),
         .miss_limit (miss_limit),
         .fill       (fill_ff),
         .look_key   (look_key),
         .key_in     (key_feed[i]),
         .match_in   (tail_match[i+1]),
         .match_out  (tail_match[i]),
         .key_out    (cell_key[i])
      );
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_if.valid) begin
         capacity_in = csr_if.payload.capacity;
      end
      fill_in   = fill_ff;
      misses_in = misses_ff;
      if (load && !hit) begin
         fill_in = keep_inc[CW-1:0];
         if (misses_ff != lmc_pkg::MISS_COUNT_MAX) begin
            misses_in = misses_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lmc_pkg::CAPACITY_RESET;
         fill_ff     <= '0;
         misses_ff   <= '0;
      end else begin
         capacity_ff <= capacity_in;
         fill_ff     <= fill_in;
         misses_ff   <= misses_in;
      end
   end

   assign rsp_word.hit        = hit;
   assign rsp_word.miss_count = misses_in;

   lmc_result_buffer u_result_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_if.valid),
      .push_word  (rsp_word),
      .push_ready (push_ready),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

/* design/lmc_checker.sv */
// Port-level checks of the LRU miss counter, bound to the top level.
// Depends on lmc_pkg and lru_miss_counter.
`default_nettype none

module lmc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 hit,
   input logic [lmc_pkg::MISS_COUNT_WIDTH-1:0] miss_count
);

   logic [1:0]                           in_flight_ff;
   logic                                 seen_ff;
   logic [lmc_pkg::MISS_COUNT_WIDTH-1:0] last_ff;
   logic                                 req_take;
   logic                                 rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
         seen_ff      <= 1'b0;
      end else begin
         in_flight_ff <= in_flight_ff + {1'b0, req_take} - {1'b0, rsp_take};
         if (rsp_take) begin
            seen_ff <= 1'b1;
         end
      end
      if (rsp_take) begin
         last_ff <= miss_count;
      end
   end

   // a result word only for a word taken earlier
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_flight_ff != 2'd0)
      else $error("result word without a pending request");

   // empty cache after reset: first lookup misses
   a_first_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !seen_ff) |-> (!hit && miss_count == 32'd1))
      else $error("first result is not a miss");

   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && seen_ff && hit) |-> miss_count == last_ff)
      else $error("miss count moved on a hit");

   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && seen_ff && !hit) |->
         (miss_count == ((last_ff == lmc_pkg::MISS_COUNT_MAX) ? last_ff : last_ff + 1'b1)))
      else $error("miss count did not step on a miss");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(hit) && $stable(miss_count)))
      else $error("stalled result word changed");

endmodule

bind lru_miss_counter lmc_checker u_lmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .hit        (rsp_if.payload.hit),
   .miss_count (rsp_if.payload.miss_count)
);

`default_nettype wire

/* test/lru_miss_counter_tb.sv */
// Self-checking testbench of lru_miss_counter: directed table, then random key streams.
// Depends on lmc_pkg, lmc_stream_if and the lru_miss_counter design files.
`default_nettype none

module lru_miss_counter_tb;

   localparam int DEPTH        = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int POOL_SIZE    = 24;
   localparam int PHASE_ITEMS  = 60;
   localparam int NUM_PHASES   = 10;
   localparam int EXP_SLOTS    = 8;

   typedef enum logic {ROW_KEY, ROW_CAP} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0]  value;
      bit           typed;
      bit           exp_hit;
      logic [31:0]  exp_count;
   } table_row_type;

   typedef struct {
      bit          hit;
      logic [31:0] miss_count;
   } lookup_result_type;

   logic clock;
   logic reset;

   lmc_stream_if #(.word_type(lmc_pkg::req_word_type)) req_if ();
   lmc_stream_if #(.word_type(lmc_pkg::rsp_word_type)) rsp_if ();
   lmc_stream_if #(.word_type(lmc_pkg::csr_word_type)) csr_if ();

   lru_miss_counter #(.ENTRIES(DEPTH), .KEY_WIDTH(lmc_pkg::REF_KEY_WIDTH)) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // shadow copy of the cache
   logic [31:0]                          lru_keys [DEPTH];
   int                                   fill_level;
   logic [lmc_pkg::MISS_COUNT_WIDTH-1:0] miss_total;
   logic [lmc_pkg::CAPACITY_WIDTH-1:0]   capacity_reg;

   // expected result words, in order of acceptance
   lookup_result_type exp_ring [EXP_SLOTS];
   int                exp_wr_count;
   int                exp_rd_count;

   int  fail_count;
   int  keys_sent;
   int  hits_seen;
   int  results_checked;
   int  cap_writes;
   int  idle_cycles;
   bit  hold_request;
   bit  rsp_steady;
   int  rsp_stall_left;

   table_row_type directed_rows[];
   logic [31:0]   key_pool [POOL_SIZE];
   int            phase_caps [NUM_PHASES];

   function automatic int clamp_capacity(logic [lmc_pkg::CAPACITY_WIDTH-1:0] cap);
      if (cap == 0)
         return 1;
      if (cap > DEPTH)
         return DEPTH;
      return int'(cap);
   endfunction

   // shift slots 0..count-1 down by one and put key on top
   task automatic shift_in_key(int count, logic [31:0] key);
      int i;
      if (count > DEPTH - 1)
         count = DEPTH - 1;
      for (i = count; i > 0; i--)
         lru_keys[i] = lru_keys[i-1];
      lru_keys[0] = key;
   endtask

   task automatic lookup_key(logic [31:0] key, output lookup_result_type res);
      int found;
      int n;
      int i;
      found = -1;
      for (i = 0; i < fill_level; i++) begin
         if (found < 0 && lru_keys[i] == key)
            found = i;
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         shift_in_key(found, key);
      end else begin
         res.hit = 1'b0;
         n = fill_level;
         if (n >= clamp_capacity(capacity_reg))
            n = clamp_capacity(capacity_reg) - 1;
         shift_in_key(n, key);
         fill_level = n + 1;
         if (miss_total != lmc_pkg::MISS_COUNT_MAX)
            miss_total = miss_total + 1'b1;
      end
      res.miss_count = miss_total;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one key word and wait for it to be taken; valid is left high
   task automatic send_key(logic [31:0] key, bit typed, bit exp_hit, logic [31:0] exp_count);
      lookup_result_type res;
      req_if.payload.ref_key <= key;
      req_if.valid           <= 1'b1;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      lookup_key(key, res);
      if (typed) begin
         res.hit        = exp_hit;
         res.miss_count = exp_count;
      end
      if (exp_wr_count - exp_rd_count >= EXP_SLOTS) begin
         $error("more than %0d result words outstanding", EXP_SLOTS);
         fail_count++;
      end
      exp_ring[exp_wr_count % EXP_SLOTS] = res;
      exp_wr_count++;
      keys_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (exp_wr_count != exp_rd_count)
         @(posedge clock);
   endtask

   task automatic write_capacity(logic [lmc_pkg::CAPACITY_WIDTH-1:0] cap);
      drain_results();
      repeat (4) @(posedge clock);
      csr_if.payload.capacity <= cap;
      csr_if.valid            <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      capacity_reg = cap;
      cap_writes++;
   endtask

   task automatic idle_sender(int gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request   = 1'b0;
         rsp_stall_left = HOLD_CYCLES;
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!rsp_steady && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 9) == 0)
               rsp_stall_left = $urandom_range(10, 40);
            else
               rsp_stall_left = $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      lookup_result_type     want;
      lmc_pkg::rsp_word_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (exp_wr_count == exp_rd_count) begin
            $error("unexpected result word: hit %0b miss_count %0d", got.hit, got.miss_count);
            fail_count++;
         end else begin
            want = exp_ring[exp_rd_count % EXP_SLOTS];
            exp_rd_count++;
            results_checked++;
            if (got.hit)
               hits_seen++;
            if (got.hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, got.hit);
               fail_count++;
            end
            if (got.miss_count !== want.miss_count) begin
               $error("miss_count: expected %0d, got %0d", want.miss_count, got.miss_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("lru_miss_counter_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int phase;
      int item;
      int i;
      int work;
      int r;
      logic [31:0] key;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready   = 1'b0;
      hold_request   = 1'b0;
      rsp_steady     = 1'b0;
      rsp_stall_left = 0;
      fail_count     = 0;
      keys_sent      = 0;
      hits_seen      = 0;
      results_checked = 0;
      cap_writes     = 0;
      idle_cycles    = 0;
      exp_wr_count   = 0;
      exp_rd_count   = 0;
      fill_level     = 0;
      miss_total     = '0;
      capacity_reg   = lmc_pkg::CAPACITY_RESET;
      for (i = 0; i < DEPTH; i++)
         lru_keys[i] = '0;

      directed_rows = '{
         '{ROW_KEY, 32'h0000_0000, 1, 0, 1},
         '{ROW_KEY, 32'h0000_0000, 1, 1, 1},
         '{ROW_KEY, 32'h7FFF_FFFF, 1, 0, 2},
         '{ROW_KEY, 32'h8000_0000, 1, 0, 3},
         '{ROW_KEY, 32'hFFFF_FFFF, 1, 0, 4},
         '{ROW_KEY, 32'h0000_0000, 1, 1, 4},
         // capacity zero acts as one; fill stays at four until a miss
         '{ROW_CAP, 32'd0,         0, 0, 0},
         '{ROW_KEY, 32'h0000_0000, 1, 1, 4},
         '{ROW_KEY, 32'h8000_0000, 1, 1, 4},
         '{ROW_KEY, 32'h0000_0005, 1, 0, 5},
         '{ROW_KEY, 32'h0000_0000, 1, 0, 6},
         '{ROW_KEY, 32'h0000_0000, 1, 1, 6},
         // above the depth clamps to the depth
         '{ROW_CAP, 32'd31,        0, 0, 0},
         '{ROW_KEY, 32'h0000_0001, 0, 0, 0},
         '{ROW_KEY, 32'h0000_0002, 0, 0, 0},
         '{ROW_KEY, 32'h0000_0003, 0, 0, 0},
         '{ROW_KEY, 32'h0000_0005, 0, 0, 0},
         '{ROW_CAP, 32'd2,         0, 0, 0},
         '{ROW_KEY, 32'hA5A5_A5A5, 0, 0, 0},
         '{ROW_KEY, 32'h0000_0001, 0, 0, 0},
         '{ROW_CAP, 32'd16,        0, 0, 0},
         '{ROW_KEY, 32'h5A5A_5A5A, 0, 0, 0},
         '{ROW_KEY, 32'hFFFF_FFFE, 0, 0, 0},
         '{ROW_CAP, 32'd1,         0, 0, 0},
         '{ROW_KEY, 32'h0000_0009, 0, 0, 0},
         '{ROW_KEY, 32'h0000_0009, 0, 0, 0}
      };
      phase_caps = '{16, 1, 2, 31, 0, 5, 8, 3, 20, 12};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].kind == ROW_CAP) begin
            write_capacity(directed_rows[i].value[lmc_pkg::CAPACITY_WIDTH-1:0]);
         end else begin
            send_key(directed_rows[i].value, directed_rows[i].typed,
                     directed_rows[i].exp_hit, directed_rows[i].exp_count);
            idle_sender(pick_gap());
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         write_capacity(phase_caps[phase][lmc_pkg::CAPACITY_WIDTH-1:0]);
         rsp_steady = (phase % 3 == 0);
         for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
         // working set around the capacity so that hits and evictions both occur
         work = $urandom_range(1, clamp_capacity(capacity_reg) + 4);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 2 && item == 10)
               hold_request = 1'b1;
            if (phase == 4 && item == 30)
               drain_results();
            r = $urandom_range(0, 99);
            if (r < 80)
               key = key_pool[$urandom_range(0, work - 1)];
            else if (r < 90)
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               key = $urandom;
            send_key(key, 0, 0, 0);
            if (!rsp_steady && !(phase == 2 && item >= 10 && item < 40))
               idle_sender(pick_gap());
         end
      end

      write_capacity(lmc_pkg::CAPACITY_RESET);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("looked up %0d keys (%0d hits) over %0d capacity writes; %0d results checked",
               keys_sent, hits_seen, cap_writes, results_checked);
      if (fail_count == 0)
         $display("lru_miss_counter_tb OK");
      else
         $display("lru_miss_counter_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
design/lmc_pkg.sv
design/lmc_stream_if.sv
design/lmc_cell.sv
design/lmc_result_buffer.sv
design/lru_miss_counter.sv
design/lmc_checker.sv
test/lru_miss_counter_tb.sv
